@@ rtl/core/input_channel_conditioner_assert.svh @@
// assertion macros for the input channel conditioner checker
// depends on a clk and an active-low rst_n in the scope that uses them
`ifndef INPUT_CHANNEL_CONDITIONER_ASSERT_SVH
`define INPUT_CHANNEL_CONDITIONER_ASSERT_SVH

// same-cycle implication, held off during reset
`define ICC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icc check failed");

// next-cycle implication, held off during reset
`define ICC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icc check failed");

`endif

@@ rtl/core/icc_pkg.sv @@
// shared types and constants for the input channel conditioner
// no dependencies
package icc_pkg;

    localparam int VAL_W   = 16;
    localparam int ACT_W   = 24;
    localparam int AREA_W  = 48;
    localparam int TRAV_W  = 32;
    localparam int TIME_W  = 32;
    localparam int CH_W    = 4;
    localparam int RATE_W  = 16;
    localparam int DZ_W    = 15;
    localparam int EN_W    = 16;
    localparam int CFG_AW  = 2;
    localparam int IN_DW   = 56;
    localparam int OUT_DW  = 144;

    typedef enum logic [CFG_AW-1:0] {
        REG_DECAY  = 2'd0,
        REG_FILTER = 2'd1,
        REG_DZONE  = 2'd2,
        REG_ENABLE = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef struct packed {
        logic [RATE_W-1:0] decay;
        logic [RATE_W-1:0] filt;
        logic [DZ_W-1:0]   dz;
        logic [EN_W-1:0]   en;
    } cfg_t;

    typedef struct packed {
        op_t                     op;
        logic [CH_W-1:0]         channel;
        logic signed [VAL_W-1:0] value;
        logic [TIME_W-1:0]       ts;
    } job_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic signed [VAL_W-1:0]  filt;
        logic [ACT_W-1:0]         act;
        logic signed [AREA_W-1:0] area;
        logic [TRAV_W-1:0]        travel;
        logic [TIME_W-1:0]        ltime;
    } row_t;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [VAL_W-1:0]  value;
        logic signed [VAL_W-1:0]  filt;
        logic [ACT_W-1:0]         act;
        logic signed [AREA_W-1:0] area;
        logic [TRAV_W-1:0]        travel;
        logic                     last;
    } res_t;

    typedef enum logic [3:0] {
        B_IDLE, B_SCAN, B_READ, B_LOAD, B_MDECAY, B_MFILT,
        B_MACT, B_MAREA, B_MVR, B_MFF, B_FSUM, B_EMIT
    } bstate_t;

endpackage

@@ rtl/core/icc_front.sv @@
// front end: accepts transactions, drops those that cause no result, queues the rest
// depends on icc_pkg
module icc_front
    import icc_pkg::*;
#(
    parameter int CHANNELS = 16
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  job_t                in_job,
    input  logic [CHANNELS-1:0] en_vec,
    output logic                q_valid,
    output job_t                q_head,
    input  logic                q_pop
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    job_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       ch_ok;
    logic       push;

    // sample for an existing, enabled channel, or a tick with some channel enabled
    assign ch_ok    = (32'(in_job.channel) < CHANNELS) && en_vec[CW'(in_job.channel)];
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready &&
                      ((in_job.op == OP_TICK) ? (|en_vec) : ch_ok);
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

@@ rtl/core/icc_back.sv @@
// back end: per-channel state memory, shared multiplier sequencer, result register
// depends on icc_pkg
module icc_back
    import icc_pkg::*;
#(
    parameter int CHANNELS = 16
)(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic [CHANNELS-1:0] en_vec,
    input  logic                q_valid,
    input  job_t                q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output res_t                out_res
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [16:0] ONE = 17'h10000;

    bstate_t state_reg, state_next;

    row_t                mem [CHANNELS];
    row_t                rd_reg;
    logic [CHANNELS-1:0] valid_reg;

    job_t                     job_reg;
    logic [CW-1:0]            ch_reg;
    row_t                     row_reg;
    logic signed [VAL_W-1:0]  nv_reg;
    logic [TIME_W-1:0]        dt_reg;
    logic [16:0]              diff_reg;
    logic [16:0]              f_reg;
    logic [16:0]              r_reg;
    logic signed [35:0]       facc_reg;
    logic signed [65:0]       prod_reg;

    logic                     out_valid_reg;
    res_t                     out_res_reg;

    logic signed [32:0] mul_a, mul_b;
    logic               mem_we;
    logic               out_load;
    logic               free;
    logic               ch_en;
    logic               is_last;
    row_t               row_in;
    row_t               wrow;

    logic signed [16:0] nv17, dz17, d17;
    logic [24:0]        act_sum;
    logic [23:0]        act_dec;
    logic [32:0]        trav_sum;
    logic signed [49:0] area_sum;
    logic signed [35:0] fsum;
    logic signed [19:0] fq;
    logic signed [VAL_W-1:0] nv_dz;

    assign free    = !out_valid_reg || out_ready;
    assign ch_en   = en_vec[ch_reg];
    assign is_last = (job_reg.op == OP_SAMPLE) || (((en_vec >> ch_reg) >> 1) == '0);
    assign row_in  = valid_reg[ch_reg] ? rd_reg : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   if (q_valid) state_next = (q_head.op == OP_TICK) ? B_SCAN : B_READ;
            B_SCAN:
            begin
                if (ch_en)
                    state_next = B_READ;
                else if (32'(ch_reg) == CHANNELS - 1)
                    state_next = B_IDLE;
            end
            B_READ:   state_next = B_LOAD;
            B_LOAD:   state_next = B_MDECAY;
            B_MDECAY: state_next = B_MFILT;
            B_MFILT:  state_next = B_MACT;
            B_MACT:   state_next = B_MAREA;
            B_MAREA:  state_next = B_MVR;
            B_MVR:    state_next = B_MFF;
            B_MFF:    state_next = B_FSUM;
            B_FSUM:   state_next = B_EMIT;
            B_EMIT:   if (free) state_next = is_last ? B_IDLE : B_SCAN;
            default:  state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop    = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            B_IDLE:   q_pop = q_valid;
            B_MDECAY:
            begin
                mul_a = $signed({17'b0, cfg.decay});
                mul_b = $signed({1'b0, dt_reg});
            end
            B_MFILT:
            begin
                mul_a = $signed({17'b0, cfg.filt});
                mul_b = $signed({1'b0, dt_reg});
            end
            B_MACT:
            begin
                mul_a = $signed({9'b0, row_reg.act});
                mul_b = $signed({16'b0, f_reg});
            end
            B_MAREA:
            begin
                mul_a = 33'(row_reg.value);
                mul_b = $signed({1'b0, dt_reg});
            end
            B_MVR:
            begin
                mul_a = 33'(row_reg.value);
                mul_b = $signed({16'b0, r_reg});
            end
            B_MFF:
            begin
                mul_a = 33'(row_reg.filt);
                mul_b = $signed({16'b0, 17'(ONE - r_reg)});
            end
            B_EMIT:
            begin
                mem_we   = free;
                out_load = free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // datapath arithmetic
    always_comb
    begin
        nv17     = 17'(nv_reg);
        dz17     = $signed({2'b0, cfg.dz});
        d17      = nv17 - 17'(row_reg.value);
        act_dec  = prod_reg[39:16];
        act_sum  = {1'b0, act_dec} + {8'b0, diff_reg};
        trav_sum = {1'b0, row_reg.travel} + {16'b0, diff_reg};
        area_sum = 50'(row_reg.area) + 50'($signed(prod_reg[48:0]));
        fsum     = facc_reg + prod_reg[35:0];
        fq       = 20'(fsum >>> 16);
        nv_dz    = ((nv17 < dz17) && (nv17 > -dz17)) ? '0 : nv_reg;
        wrow     = row_reg;
        if (job_reg.op == OP_SAMPLE)
        begin
            wrow.value = nv_dz;
        end
        wrow.ltime = job_reg.ts;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
            begin
                valid_reg[ch_reg] <= 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // state memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ch_reg] <= wrow;
        end
        rd_reg <= mem[ch_reg];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            B_IDLE:
            begin
                job_reg <= q_head;
                ch_reg  <= (q_head.op == OP_TICK) ? '0 : CW'(q_head.channel);
            end
            B_SCAN:
            begin
                if (!ch_en)
                    ch_reg <= ch_reg + 1'b1;
            end
            B_LOAD:
            begin
                row_reg  <= row_in;
                nv_reg   <= job_reg.value;
                dt_reg   <= job_reg.ts - row_in.ltime;
            end
            B_MDECAY:
            begin
                diff_reg <= (d17 < 0) ? 17'(-d17) : 17'(d17);
            end
            B_MFILT:  f_reg <= (prod_reg[65:16] != '0) ? 17'd0 : 17'(ONE - prod_reg[16:0]);
            B_MACT:   r_reg <= (prod_reg[65:16] != '0) ? ONE : prod_reg[16:0];
            B_MAREA:
            begin
                if (job_reg.op == OP_TICK)
                    row_reg.act <= act_dec;
                else
                begin
                    row_reg.act    <= act_sum[24] ? '1 : act_sum[23:0];
                    row_reg.travel <= trav_sum[32] ? '1 : trav_sum[31:0];
                end
            end
            B_MVR:
            begin
                if (area_sum[49:47] == 3'b000 || area_sum[49:47] == 3'b111)
                    row_reg.area <= area_sum[47:0];
                else
                    row_reg.area <= area_sum[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            end
            B_MFF:    facc_reg <= prod_reg[35:0] + 36'sd32768;
            B_FSUM:
            begin
                if (fq[19:15] == 5'b00000 || fq[19:15] == 5'b11111)
                    row_reg.filt <= fq[15:0];
                else
                    row_reg.filt <= fq[19] ? 16'sh8000 : 16'sh7fff;
            end
            B_EMIT:
            begin
                if (free && !is_last)
                    ch_reg <= ch_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_res_reg.channel <= CH_W'(ch_reg);
            out_res_reg.value   <= wrow.value;
            out_res_reg.filt    <= wrow.filt;
            out_res_reg.act     <= wrow.act;
            out_res_reg.area    <= wrow.area;
            out_res_reg.travel  <= wrow.travel;
            out_res_reg.last    <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

@@ rtl/core/input_channel_conditioner.sv @@
// input channel conditioner, top level: ports, configuration registers, field packing
// depends on icc_pkg, icc_front and icc_back
//
// Keeps deadzone, low-pass, decaying activity, integral and travel state for each of
// CHANNELS channels. A sample transaction (tuser 0) for an enabled channel yields one
// result with tlast set; a tick transaction (tuser 1) updates every enabled channel in
// ascending order and yields one result each, tlast on the last; samples for disabled
// channels and ticks with nothing enabled yield nothing. Transactions go into a
// two-entry queue, so the slave side keeps taking them while the back end works. The
// back end takes each channel through a memory read, a load, six steps through one
// shared 33x33 multiplier, a final filter sum and the result, after a start step that
// takes the job from the queue; on a tick it also scans each channel index from zero
// up to the highest enabled one. The result register lets the next channel proceed
// while a result waits on m_axis_tready.
// Configuration writes must only happen while no results are outstanding.
module input_channel_conditioner
    import icc_pkg::*;
#(
    parameter int CHANNELS = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [RATE_W-1:0]    cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // channel[3:0], sample_value[19:4], timestamp[51:20], zero fill above
    input  logic [IN_DW-1:0]     s_axis_tdata,
    // op[0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_channel[3:0], current_value[19:4], filtered[35:20], activity[59:36],
    // area[107:60], travel[139:108], zero fill above
    output logic [OUT_DW-1:0]    m_axis_tdata,
    output logic                 m_axis_tlast
);

    cfg_t                cfg_reg;
    logic [CHANNELS-1:0] en_vec;
    job_t                in_job;
    logic                q_valid;
    job_t                q_head;
    logic                q_pop;
    res_t                res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decay <= '0;
            cfg_reg.filt  <= 16'hffff;
            cfg_reg.dz    <= '0;
            cfg_reg.en    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_DECAY:  cfg_reg.decay <= cfg_wdata;
                REG_FILTER: cfg_reg.filt  <= cfg_wdata;
                REG_DZONE:  cfg_reg.dz    <= cfg_wdata[DZ_W-1:0];
                REG_ENABLE: cfg_reg.en    <= cfg_wdata;
                default:    cfg_reg.en    <= cfg_reg.en;
            endcase
        end
    end

    // only the first sixteen channels have enable bits
    generate
        for (genvar i = 0; i < CHANNELS; i++)
        begin : g_en
            if (i < EN_W)
            begin : g_on
                assign en_vec[i] = cfg_reg.en[i];
            end
            else
            begin : g_off
                assign en_vec[i] = 1'b0;
            end
        end
    endgenerate

    // unpack the slave transaction
    assign in_job.op      = op_t'(s_axis_tuser);
    assign in_job.channel = s_axis_tdata[3:0];
    assign in_job.value   = s_axis_tdata[19:4];
    assign in_job.ts      = s_axis_tdata[51:20];

    icc_front #(.CHANNELS(CHANNELS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_job   (in_job),
        .en_vec   (en_vec),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    icc_back #(.CHANNELS(CHANNELS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .en_vec    (en_vec),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // pack the master transaction
    assign m_axis_tdata = {4'b0, res.travel, res.area, res.act, res.filt,
                           res.value, res.channel};
    assign m_axis_tlast = res.last;

endmodule

@@ rtl/core/icc_checker.sv @@
// port-level checker for the input channel conditioner, bound to the top level
// depends on icc_pkg and input_channel_conditioner_assert.svh
`include "input_channel_conditioner_assert.svh"

module icc_checker
    import icc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_we,
    input logic [CFG_AW-1:0] cfg_addr,
    input logic [RATE_W-1:0] cfg_wdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_DW-1:0] m_axis_tdata,
    input logic              m_axis_tlast
);

    logic [EN_W-1:0] en_reg;
    logic            open_reg;
    logic [CH_W-1:0] prev_reg;
    logic            m_acc;

    assign m_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= '0;
            open_reg <= 1'b0;
            prev_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_idx_t'(cfg_addr) == REG_ENABLE)
                en_reg <= cfg_wdata;
            if (m_acc)
            begin
                open_reg <= !m_axis_tlast;
                prev_reg <= m_axis_tdata[3:0];
            end
        end
    end

    `ICC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `ICC_ASSERT_NOW(a_out_enabled, m_axis_tvalid, en_reg[m_axis_tdata[3:0]])
    `ICC_ASSERT_NOW(a_tick_ascending, m_acc && open_reg, m_axis_tdata[3:0] > prev_reg)

endmodule

bind input_channel_conditioner icc_checker u_icc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ verif/tb_input_channel_conditioner.sv @@
// testbench for the input channel conditioner: random and directed sample/tick traffic
// depends on icc_pkg and the input_channel_conditioner rtl
module tb_input_channel_conditioner;
    import icc_pkg::*;

    // one pending input transaction
    typedef struct {
        op_t              op;
        logic [3:0]       channel;
        logic [15:0]      value;
        logic [31:0]      ts;
    } event_t;

    // one expected result
    typedef struct packed {
        logic [3:0]   channel;
        logic [15:0]  value;
        logic [15:0]  filt;
        logic [23:0]  act;
        logic [47:0]  area;
        logic [31:0]  travel;
        logic         last;
    } report_t;

    localparam longint CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [RATE_W-1:0]    cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DW-1:0]     s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_DW-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    input_channel_conditioner u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // mirror of the configuration registers
    logic [15:0] decay_rate;
    logic [15:0] filter_rate;
    logic [14:0] dz_width;
    logic [15:0] chan_enable;

    // mirror of the per-channel state
    logic signed [15:0] ch_value [16];
    logic signed [15:0] ch_filt  [16];
    logic [23:0]        ch_act   [16];
    logic signed [47:0] ch_area  [16];
    logic [31:0]        ch_travel[16];
    logic [31:0]        ch_time  [16];

    event_t  pending_events[$];
    report_t expected_reports[$];

    int     errors;
    bit     idle_on;      // random stalls enabled on both sides
    longint cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // activity decay: factor 1 - rate*dt clamped at zero, truncated product
    function automatic logic [23:0] decayed(logic [23:0] a, logic [31:0] dt);
        logic [63:0] prod;
        logic [63:0] f;
        prod = 64'(decay_rate) * 64'(dt);
        f = (prod >= 64'd65536) ? 64'd0 : 64'd65536 - prod;
        return 24'((64'(a) * f) >> 16);
    endfunction

    // low-pass step toward the held value, round half up, clamped to 16 bits
    function automatic logic signed [15:0] filtered_step(logic signed [15:0] held,
                                                         logic signed [15:0] filt,
                                                         logic [31:0] dt);
        logic [63:0]  prod;
        longint       r;
        longint       sum;
        longint       q;
        prod = 64'(filter_rate) * 64'(dt);
        r = (prod >= 64'd65536) ? 65536 : longint'(prod);
        sum = longint'(held) * r + longint'(filt) * (65536 - r) + 32768;
        q = sum >>> 16;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    // decay, integral and filter for one channel
    task automatic advance_channel(int c, logic [31:0] dt);
        longint a;
        longint amax;
        amax = (longint'(1) << 47) - 1;
        ch_act[c] = decayed(ch_act[c], dt);
        a = longint'(ch_area[c]) + longint'(ch_value[c]) * longint'({32'd0, dt});
        if (a > amax) a = amax;
        if (a < -amax - 1) a = -amax - 1;
        ch_area[c] = 48'(a);
        ch_filt[c] = filtered_step(ch_value[c], ch_filt[c], dt);
    endtask

    function automatic report_t snapshot(int c, logic last);
        report_t r;
        r.channel = 4'(c);
        r.value = ch_value[c];
        r.filt = ch_filt[c];
        r.act = ch_act[c];
        r.area = ch_area[c];
        r.travel = ch_travel[c];
        r.last = last;
        return r;
    endfunction

    // integral and filter only; a sample applies decay before adding the change
    task automatic advance_channel_rest(int c, logic [31:0] dt);
        logic [23:0] keep;
        logic [15:0] rate;
        keep = ch_act[c];
        rate = decay_rate;
        decay_rate = '0;
        advance_channel(c, dt);
        decay_rate = rate;
        ch_act[c] = keep;
    endtask

    // predict the results of one accepted transaction
    task automatic predict_event(event_t e);
        logic [31:0]        dt;
        logic signed [15:0] nv;
        longint             diff;
        longint             acc;
        int                 c;
        int                 lastc;
        if (e.op == OP_SAMPLE) begin
            c = e.channel;
            if (!chan_enable[c]) return;
            nv = e.value;
            dt = e.ts - ch_time[c];
            diff = longint'(nv) - longint'(ch_value[c]);
            if (diff < 0) diff = -diff;
            ch_act[c] = decayed(ch_act[c], dt);
            acc = longint'(ch_act[c]) + diff;
            ch_act[c] = (acc > 24'hFFFFFF) ? 24'hFFFFFF : 24'(acc);
            advance_channel_rest(c, dt);
            acc = longint'(ch_travel[c]) + diff;
            ch_travel[c] = (acc > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(acc);
            if (int'(nv) < int'(dz_width) && int'(nv) > -int'(dz_width)) nv = '0;
            ch_value[c] = nv;
            ch_time[c] = e.ts;
            expected_reports.push_back(snapshot(c, 1'b1));
        end else begin
            lastc = -1;
            for (int i = 0; i < 16; i++)
                if (chan_enable[i]) lastc = i;
            for (int i = 0; i < 16; i++) begin
                if (chan_enable[i]) begin
                    dt = e.ts - ch_time[i];
                    advance_channel(i, dt);
                    ch_time[i] = e.ts;
                    expected_reports.push_back(snapshot(i, i == lastc));
                end
            end
        end
    endtask

    // driver: one transaction at a time from the pending queue
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            // previous transaction accepted (or none offered): predict it, load next
            if (s_axis_tvalid)
                predict_event(pending_events.pop_front());
            if (pending_events.size() > 0 && !(idle_on && $urandom_range(99) < 35)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_events[0].op;
                s_axis_tdata  <= {4'd0, pending_events[0].ts, pending_events[0].value,
                                  pending_events[0].channel};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        report_t exp;
        report_t got;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.channel = m_axis_tdata[3:0];
                got.value   = m_axis_tdata[19:4];
                got.filt    = m_axis_tdata[35:20];
                got.act     = m_axis_tdata[59:36];
                got.area    = m_axis_tdata[107:60];
                got.travel  = m_axis_tdata[139:108];
                got.last    = m_axis_tlast;
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result ch=%0d", $time, got.channel);
                    errors++;
                end else begin
                    exp = expected_reports.pop_front();
                    if (got !== exp) begin
                        $display("%0t: mismatch expected ch=%0d val=%h filt=%h act=%h area=%h trav=%h last=%b",
                                 $time, exp.channel, exp.value, exp.filt, exp.act, exp.area,
                                 exp.travel, exp.last);
                        $display("%0t:          actual   ch=%0d val=%h filt=%h act=%h area=%h trav=%h last=%b",
                                 $time, got.channel, got.value, got.filt, got.act, got.area,
                                 got.travel, got.last);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !(idle_on && $urandom_range(99) < 35);
        end
    end

    // run watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DECAY:  decay_rate = val;
            REG_FILTER: filter_rate = val;
            REG_DZONE:  dz_width = val[14:0];
            default:    chan_enable = val;
        endcase
    endtask

    // wait until everything offered is accepted and answered, plus tick latency
    task automatic drain();
        while (pending_events.size() > 0 || s_axis_tvalid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic add_event(op_t op, int c, logic [15:0] v, logic [31:0] ts);
        event_t e;
        e.op = op;
        e.channel = 4'(c);
        e.value = v;
        e.ts = ts;
        pending_events.push_back(e);
    endtask

    // one well-formed burst: mostly samples on random channels, some ticks, time moving
    task automatic random_burst(int n, logic [31:0] t0, int maxstep);
        logic [31:0] t;
        int          k;
        t = t0;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if ($urandom_range(9) == 0) t = $urandom;          // time jump or backwards
            else t = t + $urandom_range(maxstep);
            if (k < 15) add_event(OP_TICK, $urandom_range(15), 16'($urandom), t);
            else add_event(OP_SAMPLE, $urandom_range(15), 16'($urandom), t);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_DECAY;
        cfg_wdata = '0;
        m_axis_tready = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        errors = 0;
        idle_on = 1'b0;
        cycles = 0;
        decay_rate = 16'd0;
        filter_rate = 16'hFFFF;
        dz_width = '0;
        chan_enable = '0;
        for (int i = 0; i < 16; i++) begin
            ch_value[i] = '0; ch_filt[i] = '0; ch_act[i] = '0;
            ch_area[i] = '0; ch_travel[i] = '0; ch_time[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: everything disabled, nothing comes back
        add_event(OP_SAMPLE, 3, 16'h1234, 32'd5);
        add_event(OP_TICK, 0, 16'h0, 32'd6);
        drain();

        // directed: extremes, deadzone edges, zero dt, wrap, saturation
        write_reg(REG_ENABLE, 16'h8421);
        write_reg(REG_DZONE, 16'd100);
        write_reg(REG_FILTER, 16'd300);
        write_reg(REG_DECAY, 16'd1000);
        add_event(OP_SAMPLE, 0, 16'h7FFF, 32'd10);
        add_event(OP_SAMPLE, 0, 16'h8000, 32'd10);          // zero dt
        add_event(OP_SAMPLE, 0, 16'd99, 32'd20);            // inside deadzone
        add_event(OP_SAMPLE, 0, 16'd100, 32'd30);           // on the edge, kept
        add_event(OP_SAMPLE, 5, -16'sd99, 32'd40);
        add_event(OP_SAMPLE, 5, -16'sd100, 32'd41);
        add_event(OP_SAMPLE, 1, 16'h4000, 32'd50);          // disabled channel
        add_event(OP_SAMPLE, 15, 16'h7FFF, 32'hFFFF_FFF0);
        add_event(OP_TICK, 0, 16'h0, 32'h0000_0010);        // wraps past zero
        add_event(OP_SAMPLE, 10, 16'h8000, 32'hFFFF_FFFF);
        add_event(OP_TICK, 0, 16'h0, 32'h0000_0005);        // backwards for some
        add_event(OP_SAMPLE, 15, 16'h8000, 32'h8000_0000);  // big dt, area grows
        add_event(OP_TICK, 7, 16'hFFFF, 32'hFFFF_FFFF);
        drain();

        // extremes of the rates and deadzone, all channels on
        write_reg(REG_ENABLE, 16'hFFFF);
        write_reg(REG_DZONE, 16'h7FFF);
        write_reg(REG_FILTER, 16'hFFFF);
        write_reg(REG_DECAY, 16'hFFFF);
        add_event(OP_SAMPLE, 2, 16'h7FFF, 32'd100);
        add_event(OP_SAMPLE, 2, 16'h8000, 32'd101);
        add_event(OP_TICK, 0, 16'h0, 32'd200);
        add_event(OP_SAMPLE, 14, 16'h0001, 32'd200);
        drain();

        // random phases with varied settings; stalls on in all but one of them
        write_reg(REG_DZONE, 16'd0);
        write_reg(REG_DECAY, 16'd0);
        write_reg(REG_FILTER, 16'd0);
        idle_on = 1'b1;
        random_burst(40, $urandom, 50);
        drain();
        for (int p = 0; p < 3; p++) begin
            write_reg(REG_ENABLE, 16'($urandom));
            write_reg(REG_DZONE, 16'($urandom_range(2000)));
            write_reg(REG_DECAY, 16'($urandom_range(3000)));
            write_reg(REG_FILTER, 16'($urandom));
            idle_on = (p != 1);
            random_burst(40, $urandom, (p == 2) ? 70000 : 200);
            drain();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
